// ===== sv/rgbk_pkg.sv =====
// Shared types and constants of the RGB 3x3 kernel filter.
package rgbk_pkg;

  // Fixed field widths.
  localparam int ChanW   = 8;
  localparam int PixW    = 3 * ChanW;
  localparam int RowW    = 12;
  localparam int OutColW = 10;
  localparam int WidthW  = 11;
  localparam int HeightW = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 13;
  localparam int KernW   = 12;

  // Height limit of the row counter.
  localparam logic [HeightW-1:0] MAX_HEIGHT = 13'd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  // Kernel codes. Any other code selects emboss.
  localparam logic [1:0] MODE_SOBEL   = 2'd0;
  localparam logic [1:0] MODE_LAPLACE = 2'd1;
  localparam logic [1:0] MODE_EMBOSS  = 2'd2;

  // Tap positions within a window.
  localparam int TL = 0;
  localparam int TC = 1;
  localparam int TR = 2;
  localparam int ML = 3;
  localparam int MC = 4;
  localparam int MR = 5;
  localparam int BL = 6;
  localparam int BC = 7;
  localparam int BR = 8;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [8:0] chan_win_t;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [RowW-1:0]    out_row;
    logic [OutColW-1:0] out_col;
    logic [ChanW-1:0]   red_out;
    logic [ChanW-1:0]   green_out;
    logic [ChanW-1:0]   blue_out;
  } result_t;

endpackage

// ===== sv/rgbk_line_mem.sv =====
// Line store memory: the upper and middle line stores side by side, one read, one write port.
module rgbk_line_mem import rgbk_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [2*PixW-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [2*PixW-1:0] wr_data
);

  logic [2*PixW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/rgbk_kernel.sv =====
// One channel of the 3x3 kernel arithmetic with saturation to 0..255.
module rgbk_kernel import rgbk_pkg::*; (
  input  logic [1:0] mode,
  input  chan_win_t  win,
  output chan_t      value
);

  logic signed [KernW-1:0] t [9];
  logic signed [KernW-1:0] gx, gy, gy_adj, gy_half, v;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      t[i] = $signed({{(KernW-ChanW){1'b0}}, win[i]});
    end
    gx = t[TL] + (t[TC] <<< 1) + t[TR] - t[BL] - (t[BC] <<< 1) - t[BR];
    gy = t[TL] - t[TR] + (t[ML] <<< 1) - (t[MR] <<< 1) + t[BL] - t[BR];
    // Add one before the shift for negative values so the halving truncates toward zero.
    gy_adj  = gy + $signed({{(KernW-1){1'b0}}, gy[KernW-1]});
    gy_half = gy_adj >>> 1;
    unique case (mode)
      MODE_SOBEL:   v = gx + gy_half;
      MODE_LAPLACE: v = (t[MC] <<< 2) - t[TC] - t[BC] - t[ML] - t[MR];
      default:      v = t[MC] + t[MR] + t[BC] + (t[BR] <<< 1)
                        - (t[TL] <<< 1) - t[TC] - t[ML];
    endcase
    if (v[KernW-1] || v == '0) begin
      value = '0;
    end else if (v >= $signed(KernW'(255))) begin
      value = 8'd255;
    end else begin
      value = v[ChanW-1:0];
    end
  end

endmodule

// ===== sv/rgbk_top_dummy_never.sv =====
// Window register bank and tap assembly for the three color channels.
module rgbk_window import rgbk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  logic [PixW-1:0] top,
  input  logic [PixW-1:0] mid,
  input  logic [PixW-1:0] bot,
  output chan_win_t   win_r,
  output chan_win_t   win_g,
  output chan_win_t   win_b
);

  // Entries 0..2 hold the column two back (top, middle, bottom), 3..5 one back.
  logic [PixW-1:0] wregs [6];
  logic [PixW-1:0] px [9];

  always_comb begin
    px[TL] = wregs[0]; px[TC] = wregs[3]; px[TR] = top;
    px[ML] = wregs[1]; px[MC] = wregs[4]; px[MR] = mid;
    px[BL] = wregs[2]; px[BC] = wregs[5]; px[BR] = bot;
    for (int i = 0; i < 9; i++) begin
      win_r[i] = px[i][3*ChanW-1:2*ChanW];
      win_g[i] = px[i][2*ChanW-1:ChanW];
      win_b[i] = px[i][ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wregs[i] <= '0;
      end
    end else if (shift) begin
      wregs[0] <= wregs[3];
      wregs[1] <= wregs[4];
      wregs[2] <= wregs[5];
      wregs[3] <= top;
      wregs[4] <= mid;
      wregs[5] <= bot;
    end
  end

endmodule

// ===== sv/rgb_3x3_kernel_filter.sv =====
// Top level of the RGB 3x3 kernel filter: counters, pipeline control and configuration.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   pixel    | pixel_valid / pixel_ready  | pixel  (red_in, green_in, blue_in)
//   result   | result_valid / result_ready| result (out_row, out_col, channels)
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// The block accepts one pixel per clock unless a stalled result holds the filter
// stage. The edge that accepts a pixel also issues its line store read and loads
// the pixel into the filter stage, where it is filtered with its read data; when
// the stage moves on, its result is loaded into the output register. The single
// line store memory port pair sets the rate: one read and one write back per
// pixel. Reset clears the counters and the window registers and sets the
// configuration to its defaults; the line store is not cleared, as every entry is
// written before the filter reads it. A stalled result holds the filter stage,
// and the pixel input keeps flowing as long as the stage can drain. The cfg
// channel is always ready.
module rgb_3x3_kernel_filter import rgbk_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  pixel_t             pixel,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > WidthW) ? $clog2(MAX_WIDTH + 1) : WidthW;

  // Configuration registers.
  logic [1:0]         filter_mode;
  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;

  // Position counters of the next pixel to arrive.
  logic [CW-1:0]   column_count;
  logic [RowW-1:0] row_count;

  // Filter stage: the pixel whose line store read is in flight.
  logic            s1_valid;
  logic            s1_emit;
  logic [PixW-1:0] s1_bot;
  logic [CW-1:0]   s1_col;
  logic [RowW-1:0] s1_row;

  logic            accept, s1_go;
  logic [WW-1:0]   eff_width, col_inc;
  logic [HeightW-1:0] eff_height, row_inc;
  logic [2*PixW-1:0]  rd_data;
  logic [PixW-1:0]    top, mid;
  chan_win_t          win_r, win_g, win_b;
  chan_t              red_v, green_v, blue_v;
  logic [31:0]        col_m1, row_m1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_SOBEL;
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   filter_mode  <= cfg_data[1:0];
        CFG_WIDTH:  image_width  <= cfg_data[WidthW-1:0];
        CFG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Sizes out of range are clamped to the nearest legal one.
  always_comb begin
    if (WW'(image_width) < WW'(3)) begin
      eff_width = WW'(3);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    if (image_height < 13'd3) begin
      eff_height = 13'd3;
    end else if (image_height > MAX_HEIGHT) begin
      eff_height = MAX_HEIGHT;
    end else begin
      eff_height = image_height;
    end
    col_inc = WW'(column_count) + WW'(1);
    row_inc = HeightW'(row_count) + HeightW'(1);
  end

  // The filter stage may move on when it has nothing to deliver or the output
  // register is free or being emptied in this cycle.
  assign s1_go       = s1_valid && (!s1_emit || !result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_go;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (col_inc >= eff_width) begin
          column_count <= '0;
          row_count    <= (row_inc >= eff_height) ? '0 : row_inc[RowW-1:0];
        end else begin
          column_count <= col_inc[CW-1:0];
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bot  <= pixel;
      s1_col  <= column_count;
      s1_row  <= row_count;
      // Only pixels that complete a window around an interior pixel give a result.
      s1_emit <= (row_count >= RowW'(2)) && (CW'(column_count) >= CW'(2));
    end
  end

  // Each entry holds the upper line in its high half and the middle line in
  // its low half. Reads go out at accept; the entry is rewritten when the
  // filter stage moves on. Consecutive pixels always hit different entries.
  rgbk_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data ({mid, s1_bot})
  );

  assign top = rd_data[2*PixW-1:PixW];
  assign mid = rd_data[PixW-1:0];

  rgbk_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_go),
    .top   (top),
    .mid   (mid),
    .bot   (s1_bot),
    .win_r (win_r),
    .win_g (win_g),
    .win_b (win_b)
  );

  rgbk_kernel u_kernel_r (.mode(filter_mode), .win(win_r), .value(red_v));
  rgbk_kernel u_kernel_g (.mode(filter_mode), .win(win_g), .value(green_v));
  rgbk_kernel u_kernel_b (.mode(filter_mode), .win(win_b), .value(blue_v));

  // The window is centered one row up and one column left of the newest pixel.
  assign col_m1 = 32'(s1_col) - 32'd1;
  assign row_m1 = 32'(s1_row) - 32'd1;

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      result.out_row   <= row_m1[RowW-1:0];
      result.out_col   <= col_m1[OutColW-1:0];
      result.red_out   <= red_v;
      result.green_out <= green_v;
      result.blue_out  <= blue_v;
    end
  end

endmodule

// ===== bench/tb_rgb_3x3_kernel_filter.sv =====
// Self-checking testbench for the RGB 3x3 kernel filter, with a scoreboard that predicts each filtered pixel.
module tb_rgb_3x3_kernel_filter;
  import rgbk_pkg::*;

  // Line store depth of the instance under test.
  localparam int MaxWidth      = 1024;
  // Random pixels to send after the directed images.
  localparam int RandomItems   = 500;
  // A pixel passes through the filter stage before it reaches the result register;
  // this settle time lets a pixel without a result leave the pipe.
  localparam int SettleCycles  = 8;
  // Cycles without any accepted item before the run is declared hung.
  localparam int WatchdogLimit = 2000;
  // Register index past the end of the register list; a write there is ignored.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  // The one kernel code that the package leaves unnamed; it selects emboss.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // The scoreboard keeps its own copy of the line stores, the window, the
  // position counters and the registers. Every accepted pixel is pushed
  // through that copy, and each interior pixel leaves a filtered result in a
  // queue that the result side checks in order.
  class kernel_scoreboard;
    logic [PixW-1:0]    upper_line [MaxWidth];
    logic [PixW-1:0]    middle_line [MaxWidth];
    logic [PixW-1:0]    win_regs [6];
    logic [PixW-1:0]    taps [9];
    int                 col_cnt;
    int                 row_cnt;
    logic [1:0]         mode;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    result_t            filtered_q [$];
    int                 errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win_regs[i]) win_regs[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mode       = MODE_SOBEL;
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      errors     = 0;
    endfunction

    function void load_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        CFG_MODE:   mode = data[1:0];
        CFG_WIDTH:  width_reg = data[WidthW-1:0];
        CFG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > int'(MAX_HEIGHT)) h = int'(MAX_HEIGHT);
      return h;
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    // Filtered value of one channel of the current window.
    function logic [ChanW-1:0] kernel_value(int sh);
      int v [9];
      int gx, gy, s;
      foreach (v[i]) v[i] = (taps[i] >> sh) & 24'hFF;
      case (mode)
        MODE_SOBEL: begin
          gx = v[TL] + 2 * v[TC] + v[TR] - v[BL] - 2 * v[BC] - v[BR];
          gy = v[TL] - v[TR] + 2 * v[ML] - 2 * v[MR] + v[BL] - v[BR];
          s  = gx + gy / 2;
        end
        MODE_LAPLACE: s = 4 * v[MC] - v[TC] - v[BC] - v[ML] - v[MR];
        default: s = -2 * v[TL] - v[TC] - v[ML] + v[MC] + v[MR] + v[BC] + 2 * v[BR];
      endcase
      if (s <= 0) return 8'd0;
      if (s >= 255) return 8'd255;
      return s[7:0];
    endfunction

    function void take_pixel(pixel_t p);
      int w, h, c, r;
      logic [PixW-1:0] bot, top, mid;
      result_t res;
      w   = eff_width();
      h   = eff_height();
      c   = col_cnt;
      r   = row_cnt;
      bot = p;
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = bot;
      taps[TL] = win_regs[0];
      taps[TC] = win_regs[3];
      taps[TR] = top;
      taps[ML] = win_regs[1];
      taps[MC] = win_regs[4];
      taps[MR] = mid;
      taps[BL] = win_regs[2];
      taps[BC] = win_regs[5];
      taps[BR] = bot;
      if (r >= 2 && c >= 2) begin
        res.out_row   = RowW'(r - 1);
        res.out_col   = OutColW'(c - 1);
        res.red_out   = kernel_value(16);
        res.green_out = kernel_value(8);
        res.blue_out  = kernel_value(0);
        filtered_q.push_back(res);
      end
      win_regs[0] = win_regs[3];
      win_regs[1] = win_regs[4];
      win_regs[2] = win_regs[5];
      win_regs[3] = top;
      win_regs[4] = mid;
      win_regs[5] = bot;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (filtered_q.size() == 0) begin
        $error("filtered pixel at row %0d col %0d arrived with none pending",
               got.out_row, got.out_col);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      compare_field("out_row", want.out_row, got.out_row);
      compare_field("out_col", want.out_col, got.out_col);
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
    endfunction
  endclass

  // Every input of the block starts from a known value; reset is high from
  // time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pixel_valid = 1'b0;
  logic               pixel_ready;
  pixel_t             pixel = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;

  kernel_scoreboard sb = new();

  // Idling of each side is switched per phase, so that some stretches run
  // back to back.
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int pixels_sent  = 0;
  int pattern_idx  = 0;
  int idle_cycles  = 0;

  rgb_3x3_kernel_filter #(.MAX_WIDTH(MaxWidth)) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Inputs only ever change on the falling edge, and every handshake is
  // sampled right after the rising edge, before the block's registers move.

  // One pixel: an optional gap with valid low, then valid high until taken.
  // Valid stays high on return, so a following item with no gap keeps it up
  // without a second assignment in the same time step.
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_ready !== 1'b1) @(posedge clk);
    sb.take_pixel(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Registers are written one at a time, with a cycle of valid low between.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.load_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the pixel side until every predicted result has come back, then
  // lets the pipeline settle so that no pixel without a result is in flight.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Channel values lean toward the extremes so that saturation at both ends
  // is hit often.
  function automatic logic [ChanW-1:0] pick_chan();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red_in   = pick_chan();
    p.green_in = pick_chan();
    p.blue_in  = pick_chan();
    return p;
  endfunction

  // Directed pixels: hard black and white edges with a mid gray, which drive
  // every kernel into both rails.
  task automatic feed_pattern(int n);
    pixel_t p;
    repeat (n) begin
      p.red_in   = pattern_idx[0] ? 8'hFF : 8'h00;
      p.green_in = pattern_idx[1] ? 8'hFF : 8'h00;
      p.blue_in  = (pattern_idx % 3 == 0) ? 8'hFF : (pattern_idx % 3 == 1) ? 8'h80 : 8'h00;
      pattern_idx++;
      send_pixel(p);
    end
  endtask

  // Sends random pixels until the position counters are back at the top left.
  task automatic feed_image();
    do send_pixel(random_pixel());
    while (sb.col_cnt != 0 || sb.row_cnt != 0);
  endtask

  // Result side: a random stall before each item, then ready held high until
  // the item is taken and checked against the oldest prediction.
  initial begin : result_sink
    int stall;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall = rx_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      sb.check_result(result);
    end
  end

  // Watchdog: a run that stops accepting items on every channel is hung,
  // which also catches a predicted result that never arrives.
  always @(posedge clk) begin
    if (rst || ((pixel_valid & pixel_ready) === 1'b1) ||
        ((result_valid & result_ready) === 1'b1) || ((cfg_valid & cfg_ready) === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int start, n;
    int new_w, new_eff;
    bit set_width;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Smallest image, with both sizes written below the minimum so that they
    // act as 3, and a write to the unused index that must change nothing.
    write_reg(CFG_MODE, CfgDatW'(MODE_SOBEL));
    write_reg(CFG_WIDTH, 13'd1);
    write_reg(CFG_HEIGHT, 13'd2);
    write_reg(CFG_UNUSED, 13'h1FFF);
    feed_pattern(9);
    wait_idle();

    // A 3-wide image (width written as zero) whose kernel changes between
    // rows while the image is in progress; the spare code must act as emboss.
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'd6);
    feed_pattern(9);
    wait_idle();
    write_reg(CFG_MODE, CfgDatW'(MODE_LAPLACE));
    feed_pattern(3);
    wait_idle();
    write_reg(CFG_MODE, CfgDatW'(MODE_EMBOSS));
    feed_pattern(3);
    wait_idle();
    write_reg(CFG_MODE, CfgDatW'(MODE_SPARE));
    feed_pattern(3);
    wait_idle();

    // Wide setting: a width above the line store depth acts as the depth.
    // Only part of the first row goes in before a narrow width wraps the
    // counters early.
    write_reg(CFG_MODE, CfgDatW'($urandom_range(0, 3)));
    write_reg(CFG_WIDTH, 13'd2047);
    write_reg(CFG_HEIGHT, 13'd3);
    feed_pattern(40);
    wait_idle();

    // Tall setting, kept narrow: a height above the limit acts as the limit.
    // A low height then wraps the row counter from beyond its new end.
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    feed_pattern(30);
    wait_idle();
    write_reg(CFG_HEIGHT, 13'd4);
    feed_image();
    wait_idle();

    // Random phases with small images. Some end mid-image, so the next
    // settings take effect with the counters wherever they stand; a narrower
    // width or a lower height then wraps the counters early. A wider width is
    // only applied at the top left, so that no line store entry is read for
    // a result before it has been written.
    start = pixels_sent;
    while (pixels_sent - start < RandomItems) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      set_width    = ($urandom_range(0, 2) != 0);
      new_w        = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      new_eff      = (new_w < 3) ? 3 : new_w;
      if (set_width && new_eff > sb.eff_width() && (sb.col_cnt != 0 || sb.row_cnt != 0)) begin
        feed_image();
        wait_idle();
      end
      // Upper data bits are junk that the register must drop.
      if ($urandom_range(0, 2) != 0) write_reg(CFG_MODE, CfgDatW'($urandom_range(0, 8191)));
      if (set_width) write_reg(CFG_WIDTH, {2'($urandom_range(0, 3)), 11'(new_w)});
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_HEIGHT, CfgDatW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                   : $urandom_range(3, 8)));
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, CfgDatW'($urandom_range(0, 8191)));
      if ($urandom_range(0, 3) == 0) begin
        feed_image();
      end else begin
        n = $urandom_range(5, 60);
        repeat (n) begin
          // Now and then the sender waits for every result before going on.
          if ($urandom_range(0, 39) == 0) wait_idle();
          send_pixel(random_pixel());
        end
      end
      wait_idle();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
